// File: design/polygon_area_perimeter_top_assert.svh
// assertion macros for the polygon area and perimeter block
// expects clk and rst_n in the including module's scope
`ifndef POLYGON_AREA_PERIMETER_TOP_ASSERT_SVH
`define POLYGON_AREA_PERIMETER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pap_pkg.sv
// shared types and fixed field widths for the polygon area and perimeter block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pap_pkg;

    // control word for the bit-serial units
    typedef struct packed {
        logic load;
        logic step;
    } ser_ctl_t;

    localparam int AREA_W  = 42;
    localparam int PERIM_W = 35;
    localparam int TOTAL_W = 11;

endpackage

`default_nettype wire

// File: design/polygon_area_perimeter_top.sv
// polygon area and perimeter, top level: vertex sequencing and sums
// depends on pap_pkg, pap_smul, pap_isqrt and polygon_area_perimeter_top_assert.svh
//
// vertices come in on the input channel (vert_x, vert_y, last_vertex), one word each;
// the word with last_vertex set closes the polygon back to its first vertex and
// produces one output word (area_x2, perimeter, vertex_total, too_many)
// each edge runs four bit-serial multipliers, then a square root unit on the sum
// of the squared differences; the cross product is accumulated between the two
// in_ready is high only between vertices: a vertex that adds an edge holds the
// block until its edge is done; the first vertex and a vertex past MAX_VERTICES
// pass only through the start state unless they are the last
// the last vertex adds the closing edge, then the done state loads the output
// register once the register is free
// the output register holds the result until out_ready; new vertices are taken
// meanwhile, and a following result waits until the register is free
// reset clears all sums, the vertex count and the output valid
`timescale 1ns / 1ps
`default_nettype none

`include "polygon_area_perimeter_top_assert.svh"

module polygon_area_perimeter_top #(
    parameter int MAX_VERTICES     = 1024,
    parameter int COORD_BITS       = 16,
    parameter int LENGTH_FRAC_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [COORD_BITS-1:0]         vert_x,
    input  wire logic [COORD_BITS-1:0]         vert_y,
    input  wire logic                          last_vertex,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [pap_pkg::AREA_W-1:0]    area_x2,
    output logic      [pap_pkg::PERIM_W-1:0]   perimeter,
    output logic      [pap_pkg::TOTAL_W-1:0]   vertex_total,
    output logic                               too_many
);

    localparam int MW     = COORD_BITS + 1;
    localparam int PW     = 2 * MW;
    localparam int RW     = PW + 2 * LENGTH_FRAC_BITS;
    localparam int QW     = RW / 2;
    localparam int SEEN_W = $clog2(MAX_VERTICES + 1);
    localparam int CS_W   = PW + SEEN_W + 1;
    localparam int LS_W   = QW + SEEN_W;
    localparam int CNT_W  = $clog2(QW);
    localparam int AW_CS  = (CS_W > pap_pkg::AREA_W) ? CS_W : pap_pkg::AREA_W;
    localparam int AW_LS  = (LS_W > pap_pkg::PERIM_W) ? LS_W : pap_pkg::PERIM_W;
    localparam int AW_SN  = (SEEN_W > pap_pkg::TOTAL_W) ? SEEN_W : pap_pkg::TOTAL_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_LEN   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic                  last_reg, last_next;
    logic                  closing_reg, closing_next;
    logic [COORD_BITS-1:0] first_x_reg, first_x_next;
    logic [COORD_BITS-1:0] first_y_reg, first_y_next;
    logic [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic [CS_W-1:0]       cross_reg, cross_next;
    logic [LS_W-1:0]       length_reg, length_next;
    logic [SEEN_W-1:0]     seen_reg, seen_next;
    logic                  ovf_reg, ovf_next;
    logic                  out_valid_reg, out_valid_next;
    logic [pap_pkg::AREA_W-1:0]  area_reg, area_next;
    logic [pap_pkg::PERIM_W-1:0] perim_reg, perim_next;
    logic [pap_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                  too_many_reg, too_many_next;

    pap_pkg::ser_ctl_t mul_ctl;
    pap_pkg::ser_ctl_t sq_ctl;

    logic                  add_edge;
    logic [COORD_BITS-1:0] to_x;
    logic [COORD_BITS-1:0] to_y;
    logic [MW-1:0]         from_x_ext, from_y_ext, to_x_ext, to_y_ext;
    logic [MW-1:0]         dx, dy;
    logic [PW-1:0]         p_xy, p_yx, p_dx, p_dy;
    logic [PW-1:0]         cross_term;
    logic [PW-1:0]         d2;
    logic [RW-1:0]         rad;
    logic [QW-1:0]         root;
    logic [CS_W-1:0]       cross_abs;
    logic [AW_CS-1:0]      cross_wide;
    logic [AW_LS-1:0]      length_wide;
    logic [AW_SN-1:0]      seen_wide;
    logic                  out_free;

    assign add_edge = (seen_reg != '0) && (seen_reg < SEEN_W'(MAX_VERTICES));
    assign to_x = (state_reg == S_CLOSE) ? first_x_reg : cur_x_reg;
    assign to_y = (state_reg == S_CLOSE) ? first_y_reg : cur_y_reg;

    assign from_x_ext = {prev_x_reg[COORD_BITS-1], prev_x_reg};
    assign from_y_ext = {prev_y_reg[COORD_BITS-1], prev_y_reg};
    assign to_x_ext   = {to_x[COORD_BITS-1], to_x};
    assign to_y_ext   = {to_y[COORD_BITS-1], to_y};
    assign dx = to_x_ext - from_x_ext;
    assign dy = to_y_ext - from_y_ext;

    assign mul_ctl.load = ((state_reg == S_START) && add_edge) || (state_reg == S_CLOSE);
    assign mul_ctl.step = (state_reg == S_MUL);
    assign sq_ctl.load  = (state_reg == S_ACC);
    assign sq_ctl.step  = (state_reg == S_SQRT);

    pap_smul #(.W(MW)) u_mul_xy (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (mul_ctl),
        .a    (from_x_ext),
        .b    (to_y_ext),
        .prod (p_xy)
    );

    pap_smul #(.W(MW)) u_mul_yx (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (mul_ctl),
        .a    (from_y_ext),
        .b    (to_x_ext),
        .prod (p_yx)
    );

    pap_smul #(.W(MW)) u_mul_dx (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (mul_ctl),
        .a    (dx),
        .b    (dx),
        .prod (p_dx)
    );

    pap_smul #(.W(MW)) u_mul_dy (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (mul_ctl),
        .a    (dy),
        .b    (dy),
        .prod (p_dy)
    );

    assign cross_term = p_xy - p_yx;
    assign d2         = p_dx + p_dy;
    assign rad        = RW'(d2) << (2 * LENGTH_FRAC_BITS);

    pap_isqrt #(.RW(RW)) u_isqrt (
        .clk (clk),
        .ctl (sq_ctl),
        .rad (rad),
        .root(root)
    );

    assign cross_abs   = cross_reg[CS_W-1] ? (CS_W'(0) - cross_reg) : cross_reg;
    assign cross_wide  = AW_CS'(cross_abs);
    assign length_wide = AW_LS'(length_reg);
    assign seen_wide   = AW_SN'(seen_reg);
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        last_next      = last_reg;
        closing_next   = closing_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cross_next     = cross_reg;
        length_next    = length_reg;
        seen_next      = seen_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        area_next      = area_reg;
        perim_next     = perim_reg;
        total_next     = total_reg;
        too_many_next  = too_many_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_x_next   = vert_x;
                    cur_y_next   = vert_y;
                    last_next    = last_vertex;
                    closing_next = 1'b0;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if (seen_reg >= SEEN_W'(MAX_VERTICES))
                begin
                    ovf_next   = 1'b1;
                    state_next = last_reg ? S_CLOSE : S_IDLE;
                end
                else if (seen_reg == '0)
                begin
                    first_x_next = cur_x_reg;
                    first_y_next = cur_y_reg;
                    prev_x_next  = cur_x_reg;
                    prev_y_next  = cur_y_reg;
                    seen_next    = SEEN_W'(1);
                    state_next   = last_reg ? S_CLOSE : S_IDLE;
                end
                else
                begin
                    // multipliers load from the old previous vertex this cycle
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                    seen_next   = seen_reg + SEEN_W'(1);
                    cnt_next    = '0;
                    state_next  = S_MUL;
                end
            end
            S_CLOSE:
            begin
                closing_next = 1'b1;
                cnt_next     = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_W'(MW - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_ACC:
            begin
                cross_next = cross_reg + {{(CS_W - PW){cross_term[PW-1]}}, cross_term};
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_LEN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_LEN:
            begin
                length_next = length_reg + LS_W'(root);
                if (closing_reg)
                begin
                    state_next = S_DONE;
                end
                else if (last_reg)
                begin
                    state_next = S_CLOSE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    area_next      = cross_wide[pap_pkg::AREA_W-1:0];
                    perim_next     = length_wide[pap_pkg::PERIM_W-1:0];
                    total_next     = seen_wide[pap_pkg::TOTAL_W-1:0];
                    too_many_next  = ovf_reg;
                    first_x_next   = '0;
                    first_y_next   = '0;
                    prev_x_next    = '0;
                    prev_y_next    = '0;
                    cross_next     = '0;
                    length_next    = '0;
                    seen_next      = '0;
                    ovf_next       = 1'b0;
                    closing_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            closing_reg   <= 1'b0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            cross_reg     <= '0;
            length_reg    <= '0;
            seen_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            closing_reg   <= closing_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            cross_reg     <= cross_next;
            length_reg    <= length_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        area_reg     <= area_next;
        perim_reg    <= perim_next;
        total_reg    <= total_next;
        too_many_reg <= too_many_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign area_x2      = area_reg;
    assign perimeter    = perim_reg;
    assign vertex_total = total_reg;
    assign too_many     = too_many_reg;

    `PAP_ASSERT_NOW(a_seen_bound, 1'b1, seen_reg <= SEEN_W'(MAX_VERTICES), "vertex count past max")
    `PAP_ASSERT_NOW(a_close_on_last, closing_reg, last_reg, "closing edge without last vertex")
    `PAP_ASSERT_NOW(a_out_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE, "result not from done")
    `PAP_ASSERT_NEXT(a_accept_start, in_valid && in_ready, state_reg == S_START, "accept did not start")

endmodule

`default_nettype wire

// File: design/pap_smul.sv
// bit-serial signed multiplier, one multiplier bit per step
// depends on pap_pkg
`timescale 1ns / 1ps
`default_nettype none

module pap_smul #(
    parameter int W = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pap_pkg::ser_ctl_t ctl,
    input  wire logic [W-1:0]      a,
    input  wire logic [W-1:0]      b,
    output logic      [2*W-1:0]    prod
);

    localparam int SW = $clog2(W);

    logic [W-1:0]  mcand_reg, mcand_next;
    logic [W:0]    hi_reg, hi_next;
    logic [W-1:0]  lo_reg, lo_next;
    logic [SW-1:0] step_reg, step_next;

    logic [W:0] mc_ext;
    logic [W:0] addend;
    logic [W:0] sum;

    assign mc_ext = {mcand_reg[W-1], mcand_reg};
    assign addend = lo_reg[0] ? mc_ext : '0;
    // sign bit of the multiplier carries negative weight
    assign sum = (step_reg == SW'(W - 1)) ? (hi_reg - addend) : (hi_reg + addend);

    always_comb
    begin
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        step_next  = step_reg;
        if (ctl.load)
        begin
            mcand_next = a;
            hi_next    = '0;
            lo_next    = b;
            step_next  = '0;
        end
        else if (ctl.step)
        begin
            hi_next   = {sum[W], sum[W:1]};
            lo_next   = {sum[0], lo_reg[W-1:1]};
            step_next = step_reg + SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign prod = {hi_reg[W-1:0], lo_reg};

endmodule

`default_nettype wire

// File: design/pap_isqrt.sv
// digit-by-digit integer square root, one root bit per step
// depends on pap_pkg
`timescale 1ns / 1ps
`default_nettype none

module pap_isqrt #(
    parameter int RW = 50
) (
    input  wire logic              clk,
    input  wire pap_pkg::ser_ctl_t ctl,
    input  wire logic [RW-1:0]     rad,
    output logic      [RW/2-1:0]   root
);

    localparam int QW = RW / 2;

    logic [RW-1:0] rad_reg, rad_next;
    logic [QW:0]   rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;

    logic [QW+2:0] cat;
    logic [QW+2:0] trial;
    logic [QW+2:0] diff;
    logic          ge;

    assign cat   = {rem_reg, rad_reg[RW-1 -: 2]};
    assign trial = {1'b0, q_reg, 2'b01};
    assign ge    = (cat >= trial);
    assign diff  = cat - trial;

    always_comb
    begin
        rad_next = rad_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        if (ctl.load)
        begin
            rad_next = rad;
            rem_next = '0;
            q_next   = '0;
        end
        else if (ctl.step)
        begin
            rad_next = {rad_reg[RW-3:0], 2'b00};
            rem_next = ge ? diff[QW:0] : cat[QW:0];
            q_next   = {q_reg[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign root = q_reg;

endmodule

`default_nettype wire
